@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the sine and cosine core.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Same-cycle implication that also holds during reset.
`define ASSERT_ALWAYS(label, clk, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/scp_pkg.sv @@
// Shared constants and types of the sine and cosine polynomial core.
// Depends on nothing; the core's design files refer to it by scoped names.
`default_nettype none

package scp_pkg;

	// Reduction works in Q46; the high word of the shifted angle feeds the estimate.
	localparam int RED_FRAC    = 46;
	localparam int HI_SHIFT    = 32;
	localparam int RECIP_SHIFT = 46;
	localparam int R0_W        = 52;
	localparam int R_W         = 49;
	localparam int X_W         = 32;
	localparam int ACC_W       = 34;
	localparam int PROD_W      = 2 * ACC_W;

	localparam int RED_STAGES  = 5;
	localparam int POLY_STAGES = 13;
	localparam int NUM_STAGES  = RED_STAGES + POLY_STAGES;

	typedef logic [NUM_STAGES-1:0] stage_en_t;

	localparam logic signed [63:0] PI_Q46      = 64'sh0000_C90F_DAA2_2169;
	localparam logic signed [63:0] TWO_PI_Q46  = 64'sh0001_921F_B544_42D2;
	localparam logic signed [63:0] HALF_PI_Q46 = 64'sh0000_6487_ED51_10B4;

	// floor(2^78 / 2pi in Q46)
	localparam logic [30:0] RECIP_Q78 = 31'd683565275;

	localparam logic [R0_W-1:0]        TWO_PI_R0 = R0_W'(TWO_PI_Q46);
	localparam logic signed [R0_W-1:0] PI_R0     = R0_W'(PI_Q46);
	localparam logic signed [R0_W-1:0] PI3_R0    = R0_W'(64'sd3 * PI_Q46);
	localparam logic signed [R0_W-1:0] PI5_R0    = R0_W'(64'sd5 * PI_Q46);

	localparam logic signed [63:0] HALF_LSB17 = 64'sd65536;
	localparam logic signed [63:0] HALF_LSB29 = 64'sd268435456;
	localparam logic signed [63:0] HALF_LSB30 = 64'sd536870912;

	// Remove j whole turns and add the rounding half of the Q29 step in one go.
	localparam logic signed [R0_W-1:0] JT_Q46 [4] = '{
		R0_W'(HALF_LSB17),
		R0_W'(HALF_LSB17 - TWO_PI_Q46),
		R0_W'(HALF_LSB17 - 64'sd2 * TWO_PI_Q46),
		R0_W'(HALF_LSB17 - 64'sd3 * TWO_PI_Q46)
	};

	localparam longint C3_Q31 = -64'sd357913941;
	localparam longint C5_Q31 = 64'sd17895697;
	localparam longint C7_Q31 = -64'sd426088;
	localparam longint C9_Q31 = 64'sd5918;

	localparam logic signed [ACC_W-1:0] C9_A = ACC_W'(C9_Q31);

	// Horner addend with rounding folded in: c * 2^29 + 2^28.
	localparam logic signed [PROD_W-1:0] K7_P = PROD_W'(C7_Q31 * HALF_LSB30 + HALF_LSB29);
	localparam logic signed [PROD_W-1:0] K5_P = PROD_W'(C5_Q31 * HALF_LSB30 + HALF_LSB29);
	localparam logic signed [PROD_W-1:0] K3_P = PROD_W'(C3_Q31 * HALF_LSB30 + HALF_LSB29);
	localparam logic signed [PROD_W-1:0] RND29_P = PROD_W'(HALF_LSB29);
	localparam logic signed [PROD_W-1:0] RND30_P = PROD_W'(HALF_LSB30);

	localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-64'sd2147483648);

endpackage

`default_nettype wire

@@ rtl/scp_ctrl.sv @@
// Pipeline control: one valid bit per stage and the per-stage load enables.
// Depends on scp_pkg for the stage count.
`default_nettype none

module scp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                angle_valid,
	input  logic                result_stall,
	output logic                angle_stall,
	output logic                result_valid,
	output scp_pkg::stage_en_t  en
);

	localparam int N = scp_pkg::NUM_STAGES;

	logic [N-1:0] vld_q;

	// A stage loads when it is empty or some stage at or after it is empty,
	// or the output is being taken: bubbles close up behind a stalled result.
	for (genvar g = 0; g < N; g++) begin : g_en
		assign en[g] = !result_stall || !(&vld_q[N-1:g]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~en) | ({vld_q[N-2:0], angle_valid} & en);
		end
	end

	assign angle_stall  = !en[0];
	assign result_valid = vld_q[N-1];

endmodule

`default_nettype wire

@@ rtl/scp_reduce.sv @@
// Range reduction of both lanes (angle and angle plus pi/2) into (-pi, pi],
// rounded to Q29. Five stages; depends on scp_pkg for constants.
`default_nettype none

module scp_reduce #(
	parameter int ANGLE_FRAC_BITS = 24
) (
	input  logic                              clk,
	input  logic [scp_pkg::RED_STAGES-1:0]    en,
	input  logic signed [31:0]                angle,
	output logic signed [scp_pkg::X_W-1:0]    x_sin,
	output logic signed [scp_pkg::X_W-1:0]    x_cos
);

	localparam int SH   = scp_pkg::RED_FRAC - ANGLE_FRAC_BITS;
	localparam int V_W  = 32 + SH + 2;
	localparam int TH_W = V_W - scp_pkg::HI_SHIFT;
	localparam int P_W  = TH_W + 31;
	localparam int K_W  = P_W - scp_pkg::RECIP_SHIFT;
	localparam int R0_W = scp_pkg::R0_W;
	localparam int X_W  = scp_pkg::X_W;

	localparam logic signed [63:0] OFF [2] = '{64'sd0, scp_pkg::HALF_PI_Q46};

	logic signed [X_W-1:0] x_s5 [2];

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [V_W-1:0]       v;
		logic signed [V_W-1:0]       t;
		logic signed [TH_W-1:0]      t_hi_s1;
		logic [R0_W-1:0]             vlo_s1;
		logic signed [P_W-1:0]       prod;
		logic signed [K_W-1:0]       k_est;
		logic signed [K_W-1:0]       k_est_s2;
		logic [R0_W-1:0]             vlo_s2;
		logic signed [K_W+R0_W:0]    kp_full;
		logic [R0_W-1:0]             kp_s3;
		logic [R0_W-1:0]             vlo_s3;
		logic signed [R0_W-1:0]      r0_s4;
		logic [1:0]                  j;
		logic signed [R0_W-1:0]      xr;

		always_comb begin
			v = V_W'(angle) <<< SH;
			t = v + V_W'(OFF[l] - scp_pkg::PI_Q46);
			prod = t_hi_s1 * $signed({1'b0, scp_pkg::RECIP_Q78});
			// bias low by one so the true turn count is never below the estimate
			k_est = prod[P_W-1:scp_pkg::RECIP_SHIFT] - K_W'(1);
			kp_full = k_est_s2 * $signed({1'b0, scp_pkg::TWO_PI_R0});
			j = 2'(r0_s4 > scp_pkg::PI_R0) + 2'(r0_s4 > scp_pkg::PI3_R0)
				+ 2'(r0_s4 > scp_pkg::PI5_R0);
			xr = r0_s4 + scp_pkg::JT_Q46[j];
		end

		always_ff @(posedge clk) begin
			if (en[0]) begin
				t_hi_s1 <= t[V_W-1:scp_pkg::HI_SHIFT];
				vlo_s1  <= v[R0_W-1:0] + R0_W'(OFF[l]);
			end
			if (en[1]) begin
				k_est_s2 <= k_est;
				vlo_s2   <= vlo_s1;
			end
			if (en[2]) begin
				kp_s3  <= kp_full[R0_W-1:0];
				vlo_s3 <= vlo_s2;
			end
			if (en[3]) begin
				r0_s4 <= vlo_s3 - kp_s3;
			end
			if (en[4]) begin
				x_s5[l] <= xr[scp_pkg::R_W-1:scp_pkg::R_W-X_W];
			end
		end
	end

	assign x_sin = x_s5[0];
	assign x_cos = x_s5[1];

endmodule

`default_nettype wire

@@ rtl/scp_poly.sv @@
// Odd degree-9 polynomial by Horner's rule on x squared, one lane, 13 stages,
// ending in the output register. Depends on scp_pkg for coefficients.
`default_nettype none

module scp_poly #(
	parameter int OUT_FRAC_BITS = 30
) (
	input  logic                               clk,
	input  logic [scp_pkg::POLY_STAGES-1:0]    en,
	input  logic signed [scp_pkg::X_W-1:0]     x_in,
	output logic signed [31:0]                 y
);

	localparam int OSH    = 30 - OUT_FRAC_BITS;
	localparam int X_W    = scp_pkg::X_W;
	localparam int ACC_W  = scp_pkg::ACC_W;
	localparam int PROD_W = scp_pkg::PROD_W;

	logic signed [X_W-1:0]    x_s [6:16];
	logic signed [ACC_W-1:0]  x2_s [7:13];
	logic signed [2*X_W-1:0]  xx_s6;
	logic signed [2*X_W-1:0]  xx_rnd;
	logic signed [PROD_W-1:0] m1_s8, m2_s10, m3_s12, m4_s14, m5_s16;
	logic signed [PROD_W-1:0] a1_sum, a2_sum, a3_sum, t_sum, s_sum;
	logic signed [ACC_W-1:0]  acc1_s9, acc2_s11, acc3_s13, t_s15, s_s17;
	logic signed [ACC_W-1:0]  s_rnd;
	logic signed [31:0]       y_s18;

	always_comb begin
		xx_rnd = xx_s6 + (2*X_W)'(scp_pkg::HALF_LSB29);
		a1_sum = m1_s8 + scp_pkg::K7_P;
		a2_sum = m2_s10 + scp_pkg::K5_P;
		a3_sum = m3_s12 + scp_pkg::K3_P;
		t_sum  = m4_s14 + scp_pkg::RND29_P;
		// x enters at weight 2^31, so it folds into the final rounding add
		s_sum  = m5_s16 + scp_pkg::RND30_P + (PROD_W'(x_s[16]) <<< 31);
	end

	if (OSH == 0) begin : g_no_rnd
		assign s_rnd = s_s17;
	end else begin : g_rnd
		assign s_rnd = (s_s17 + (ACC_W'(1) <<< (OSH - 1))) >>> OSH;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s[6] <= x_in;
			xx_s6  <= x_in * x_in;
		end
		for (int k = 7; k <= 16; k++) begin
			if (en[k-6]) begin
				x_s[k] <= x_s[k-1];
			end
		end
		if (en[1]) begin
			x2_s[7] <= xx_rnd[29+ACC_W-1:29];
		end
		for (int k = 8; k <= 13; k++) begin
			if (en[k-6]) begin
				x2_s[k] <= x2_s[k-1];
			end
		end
		if (en[2]) begin
			m1_s8 <= x2_s[7] * scp_pkg::C9_A;
		end
		if (en[3]) begin
			acc1_s9 <= a1_sum[29+ACC_W-1:29];
		end
		if (en[4]) begin
			m2_s10 <= acc1_s9 * x2_s[9];
		end
		if (en[5]) begin
			acc2_s11 <= a2_sum[29+ACC_W-1:29];
		end
		if (en[6]) begin
			m3_s12 <= acc2_s11 * x2_s[11];
		end
		if (en[7]) begin
			acc3_s13 <= a3_sum[29+ACC_W-1:29];
		end
		if (en[8]) begin
			m4_s14 <= acc3_s13 * x2_s[13];
		end
		if (en[9]) begin
			t_s15 <= t_sum[29+ACC_W-1:29];
		end
		if (en[10]) begin
			m5_s16 <= t_s15 * ACC_W'(x_s[15]);
		end
		if (en[11]) begin
			s_s17 <= s_sum[30+ACC_W-1:30];
		end
		if (en[12]) begin
			// clamp to the 32-bit result range
			if (s_rnd > scp_pkg::OUT_MAX) begin
				y_s18 <= scp_pkg::OUT_MAX[31:0];
			end else if (s_rnd < scp_pkg::OUT_MIN) begin
				y_s18 <= scp_pkg::OUT_MIN[31:0];
			end else begin
				y_s18 <= s_rnd[31:0];
			end
		end
	end

	assign y = y_s18;

endmodule

`default_nettype wire

@@ rtl/sine_cosine_polynomial_core.sv @@
// Sine and cosine core: one signed fixed-point angle in, sine and cosine out.
// Depends on scp_pkg, scp_ctrl, scp_reduce and scp_poly.
//
// Input channel: angle (Q7.24 radians by default), with angle_valid and
// angle_stall. Output channel: sine and cosine (Q1.30 by default), with
// result_valid and result_stall. A beat moves when valid is high and stall low.
// Cosine is the polynomial sine of the angle plus pi/2.
//
// Throughput: one angle per cycle while result_stall is low. From the angle
// beat to its result beat the pipe runs through five reduction stages (shifted
// angle register, turn estimate by reciprocal multiply, turn product, subtract,
// correction with rounding to Q29) and thirteen polynomial stages (one
// multiplier each for x squared, four Horner products and the final product
// by x, each followed by a rounding add stage, then the clamped output).
//
// When the receiver stalls, the result holds and the stages behind it keep
// filling until every stage holds a beat; only then does angle_stall rise.
// Reset clears all valid bits at once; no result is shown until an angle has
// gone through.
`default_nettype none

module sine_cosine_polynomial_core #(
	parameter int ANGLE_FRAC_BITS = 24,
	parameter int OUT_FRAC_BITS   = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               angle_valid,
	output logic               angle_stall,
	input  logic signed [31:0] angle,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] sine,
	output logic signed [31:0] cosine
);

	scp_pkg::stage_en_t              en;
	logic signed [scp_pkg::X_W-1:0]  x_sin;
	logic signed [scp_pkg::X_W-1:0]  x_cos;

	// Valid bits and load enables for every stage.
	scp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.angle_valid  (angle_valid),
		.result_stall (result_stall),
		.angle_stall  (angle_stall),
		.result_valid (result_valid),
		.en           (en)
	);

	// Bring both lanes into (-pi, pi] and round to Q29.
	scp_reduce #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_reduce (
		.clk   (clk),
		.en    (en[scp_pkg::RED_STAGES-1:0]),
		.angle (angle),
		.x_sin (x_sin),
		.x_cos (x_cos)
	);

	// Evaluate the polynomial on each lane.
	scp_poly #(
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_poly_sin (
		.clk  (clk),
		.en   (en[scp_pkg::NUM_STAGES-1:scp_pkg::RED_STAGES]),
		.x_in (x_sin),
		.y    (sine)
	);

	scp_poly #(
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_poly_cos (
		.clk  (clk),
		.en   (en[scp_pkg::NUM_STAGES-1:scp_pkg::RED_STAGES]),
		.x_in (x_cos),
		.y    (cosine)
	);

endmodule

`default_nettype wire

@@ rtl/scp_checker.sv @@
// Port-level checks of the sine and cosine core, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module scp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               angle_valid,
	input logic               angle_stall,
	input logic signed [31:0] angle,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [31:0] sine,
	input logic signed [31:0] cosine
);

	// The input only backs up when a result is held and every stage is full.
	`ASSERT_NOW(a_stall_blocked, clk, arst_n, angle_stall, result_valid && result_stall, "angle_stall without a held result")

	// A stalled result stays up and unchanged.
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(sine) && $stable(cosine), "stalled result changed or dropped")

	// A stalled angle beat stays offered and unchanged.
	`ASSERT_NEXT(a_angle_hold, clk, arst_n, angle_valid && angle_stall, angle_valid && $stable(angle), "stalled angle changed or dropped")

	// Reset empties the pipe and leaves the input open.
	`ASSERT_ALWAYS(a_reset_empty, clk, !arst_n, !result_valid && !angle_stall, "pipe not empty during reset")

endmodule

bind sine_cosine_polynomial_core scp_checker u_scp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.angle_valid  (angle_valid),
	.angle_stall  (angle_stall),
	.angle        (angle),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.sine         (sine),
	.cosine       (cosine)
);

`default_nettype wire
